### hdl/orcr_pkg.sv
// orcr_pkg: shared types, constants, saturation helpers and the sequencer microprogram
// for the output rc filter resampler; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package orcr_pkg;

	localparam int PHASE_FRAC_BITS = 20;
	localparam logic [31:0] ONE_TICK = 32'd1 << PHASE_FRAC_BITS;

	// register reset values
	localparam logic [30:0] HPC_RST  = 31'd108980;
	localparam logic [30:0] LPC_RST  = 31'd108980000;
	localparam logic [26:0] STEP_RST = 27'd21523000;
	localparam logic [15:0] GAIN_RST = 16'd655;

	// configuration register indexes
	localparam logic [1:0] REG_HIGHPASS_COEFF = 2'd0;
	localparam logic [1:0] REG_LOWPASS_COEFF  = 2'd1;
	localparam logic [1:0] REG_RESAMPLE_STEP  = 2'd2;
	localparam logic [1:0] REG_OUTPUT_GAIN    = 2'd3;

	// microprogram step addresses
	typedef logic [3:0] step_t;
	localparam step_t STEP_WAIT   = 4'd0;
	localparam step_t STEP_E      = 4'd1;
	localparam step_t STEP_HP_LO  = 4'd2;
	localparam step_t STEP_HP_HI  = 4'd3;
	localparam step_t STEP_LP_LO  = 4'd4;
	localparam step_t STEP_LP_HI  = 4'd5;
	localparam step_t STEP_G_LO   = 4'd6;
	localparam step_t STEP_G_HI   = 4'd7;
	localparam step_t STEP_G_ADD  = 4'd8;
	localparam step_t STEP_GAIN   = 4'd9;
	localparam step_t STEP_PHASE  = 4'd10;
	localparam step_t STEP_EMIT   = 4'd11;
	localparam step_t STEP_END    = 4'd12;

	typedef enum logic [2:0] {A_DLO, A_DHI, A_ELO, A_EHI, A_PHASE} a_sel_t;
	typedef enum logic [1:0] {B_HPC, B_LPC, B_GAIN, B_DIFF} b_sel_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD_LO, ACC_ADD_HI} acc_op_t;
	typedef enum logic [3:0] {
		WB_NONE, WB_D, WB_E_DMAG, WB_EMAG, WB_HP, WB_LP, WB_GAIN, WB_OUT, WB_END
	} wb_t;
	typedef enum logic [2:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT, JMP_NO_EMIT, JMP_GOTO} jmp_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		wb_t     wb;
		jmp_t    jmp;
		step_t   target;
	} ctrl_t;

	typedef struct packed {
		ctrl_t word;
		logic  go;
	} ctl_t;

	typedef struct packed {
		logic emit;
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic [30:0] hpc;
		logic [30:0] lpc;
		logic [26:0] step;
		logic [15:0] gain;
	} cfg_t;

	function automatic logic signed [55:0] sat56(input logic signed [58:0] v);
		logic signed [55:0] r;
		if (v[58:55] == {4{v[58]}}) begin
			r = v[55:0];
		end else if (v[58]) begin
			r = {1'b1, {55{1'b0}}};
		end else begin
			r = {1'b0, {55{1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [57:0] v);
		logic signed [23:0] r;
		if (v[57:23] == {35{v[57]}}) begin
			r = v[23:0];
		end else if (v[57]) begin
			r = {1'b1, {23{1'b0}}};
		end else begin
			r = {1'b0, {23{1'b1}}};
		end
		return r;
	endfunction

	function automatic ctrl_t prog_rom(input step_t s);
		ctrl_t w;
		w.a_sel  = A_DLO;
		w.b_sel  = B_HPC;
		w.acc_op = ACC_HOLD;
		w.wb     = WB_NONE;
		w.jmp    = JMP_NEXT;
		w.target = STEP_WAIT;
		case (s)
			STEP_WAIT: begin
				w.wb  = WB_D;
				w.jmp = JMP_WAIT_IN;
			end
			STEP_E: begin
				w.wb = WB_E_DMAG;
			end
			STEP_HP_LO: begin
				w.wb = WB_EMAG;
			end
			STEP_HP_HI: begin
				w.a_sel  = A_DHI;
				w.acc_op = ACC_LOAD_LO;
			end
			STEP_LP_LO: begin
				w.a_sel  = A_ELO;
				w.b_sel  = B_LPC;
				w.acc_op = ACC_ADD_HI;
			end
			STEP_LP_HI: begin
				w.a_sel  = A_EHI;
				w.b_sel  = B_LPC;
				w.acc_op = ACC_LOAD_LO;
				w.wb     = WB_HP;
			end
			STEP_G_LO: begin
				w.b_sel  = B_GAIN;
				w.acc_op = ACC_ADD_HI;
			end
			STEP_G_HI: begin
				w.a_sel  = A_DHI;
				w.b_sel  = B_GAIN;
				w.acc_op = ACC_LOAD_LO;
				w.wb     = WB_LP;
			end
			STEP_G_ADD: begin
				w.acc_op = ACC_ADD_HI;
			end
			STEP_GAIN: begin
				w.wb = WB_GAIN;
			end
			STEP_PHASE: begin
				w.a_sel  = A_PHASE;
				w.b_sel  = B_DIFF;
				w.jmp    = JMP_NO_EMIT;
				w.target = STEP_END;
			end
			STEP_EMIT: begin
				// same operands as the previous step keep the product steady while stalled
				w.a_sel = A_PHASE;
				w.b_sel = B_DIFF;
				w.wb    = WB_OUT;
				w.jmp   = JMP_WAIT_OUT;
			end
			STEP_END: begin
				w.wb     = WB_END;
				w.jmp    = JMP_GOTO;
				w.target = STEP_WAIT;
			end
			default: begin
				w.jmp    = JMP_GOTO;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### hdl/output_rc_filter_resampler_core.sv
// output_rc_filter_resampler_core: microcoded sequencer, configuration registers and stream
// ports of the rc output filter with linear resampler; depends on orcr_pkg, orcr_datapath
// a result is registered in the emit step of the program run for its item
// one item at a time; items without a result skip the emit step; the steps share one 33x33
// multiplier used in 7 program steps; an item is taken only in the wait step
// a held result stalls the emit step only
// reset: filter levels, phase and previous level clear to zero, registers take their defaults
`timescale 1ns / 1ps
`default_nettype none

module output_rc_filter_resampler_core import orcr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [23:0] level_in
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [23:0] m_axis_tdata,  // [23:0] sample_out
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);

	step_t   step_q;
	step_t   step_next;
	ctrl_t   word;
	ctl_t    ctl;
	status_t status;
	cfg_t    cfg_q;
	logic signed [23:0] sample;

	assign word      = prog_rom(step_q);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hpc  <= HPC_RST;
			cfg_q.lpc  <= LPC_RST;
			cfg_q.step <= STEP_RST;
			cfg_q.gain <= GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HIGHPASS_COEFF: cfg_q.hpc  <= cfg_data;
				REG_LOWPASS_COEFF:  cfg_q.lpc  <= cfg_data;
				REG_RESAMPLE_STEP:  cfg_q.step <= cfg_data[26:0];
				REG_OUTPUT_GAIN:    cfg_q.gain <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl.word      = word;
		ctl.go        = 1'b1;
		s_axis_tready = 1'b0;
		step_next     = step_q + 4'd1;
		case (word.jmp)
			JMP_WAIT_IN: begin
				s_axis_tready = 1'b1;
				ctl.go        = s_axis_tvalid;
				step_next     = s_axis_tvalid ? step_q + 4'd1 : step_q;
			end
			JMP_WAIT_OUT: begin
				ctl.go    = !status.out_busy;
				step_next = status.out_busy ? step_q : step_q + 4'd1;
			end
			JMP_NO_EMIT: step_next = status.emit ? step_q + 4'd1 : word.target;
			JMP_GOTO:    step_next = word.target;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_next;
		end
	end

	orcr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg        (cfg_q),
		.level_in   (s_axis_tdata),
		.out_ready  (m_axis_tready),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.sample_out (sample)
	);

	assign m_axis_tdata = sample;

endmodule

`default_nettype wire

### hdl/orcr_datapath.sv
// orcr_datapath: filter state, shared multiplier, accumulator and output register,
// driven one control word per cycle; depends on orcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module orcr_datapath import orcr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctl_t               ctl,
	input  wire cfg_t               cfg,
	input  wire logic signed [23:0] level_in,
	input  wire logic               out_ready,
	output      status_t            status,
	output      logic               out_valid,
	output      logic signed [23:0] sample_out
);

	logic signed [55:0] lp_q;
	logic signed [55:0] hp_q;
	logic        [31:0] phase_q;
	logic signed [23:0] prev_q;
	logic               out_valid_q;
	logic signed [23:0] sample_q;

	logic signed [23:0] x_q;
	logic signed [55:0] d_q;
	logic signed [55:0] e_q;
	logic        [55:0] dmag_q;
	logic               dneg_q;
	logic        [55:0] emag_q;
	logic               eneg_q;
	logic signed [65:0] prod_q;
	logic        [57:0] acc_q;
	logic signed [23:0] s_q;

	logic signed [32:0] a_op;
	logic signed [32:0] b_op;
	logic signed [24:0] diff;
	logic signed [58:0] lp_ext;
	logic signed [58:0] hp_ext;
	logic signed [58:0] acc_ext;
	logic signed [58:0] x_ext;
	logic signed [58:0] hp_sum;
	logic signed [58:0] lp_sum;
	logic signed [65:0] prod_sh;
	logic signed [57:0] interp;
	logic        [41:0] gain_mag;
	logic signed [24:0] gain_neg;
	logic signed [23:0] gain_val;
	logic               wr;

	assign wr       = ctl.go;
	assign diff     = {s_q[23], s_q} - {prev_q[23], prev_q};
	assign lp_ext   = {{3{lp_q[55]}}, lp_q};
	assign hp_ext   = {{3{hp_q[55]}}, hp_q};
	assign acc_ext  = {1'b0, acc_q};
	assign x_ext    = {{5{x_q[23]}}, x_q, 30'b0};
	assign hp_sum   = dneg_q ? hp_ext - acc_ext : hp_ext + acc_ext;
	assign lp_sum   = eneg_q ? lp_ext - acc_ext : lp_ext + acc_ext;
	assign prod_sh  = prod_q >>> PHASE_FRAC_BITS;
	assign interp   = {{34{prev_q[23]}}, prev_q} + prod_sh[57:0];
	assign gain_mag = acc_q[57:16];
	assign gain_neg = -$signed({1'b0, gain_mag[23:0]});

	always_comb begin
		if (dneg_q) begin
			gain_val = (gain_mag > 42'd8388608) ? {1'b1, {23{1'b0}}} : gain_neg[23:0];
		end else begin
			gain_val = (gain_mag > 42'd8388607) ? {1'b0, {23{1'b1}}} : gain_mag[23:0];
		end
	end

	always_comb begin
		case (ctl.word.a_sel)
			A_DLO:   a_op = {3'b0, dmag_q[29:0]};
			A_DHI:   a_op = {7'b0, dmag_q[55:30]};
			A_ELO:   a_op = {3'b0, emag_q[29:0]};
			A_EHI:   a_op = {7'b0, emag_q[55:30]};
			A_PHASE: a_op = {phase_q[31], phase_q};
			default: a_op = '0;
		endcase
		case (ctl.word.b_sel)
			B_HPC:   b_op = {2'b0, cfg.hpc};
			B_LPC:   b_op = {2'b0, cfg.lpc};
			B_GAIN:  b_op = {17'b0, cfg.gain};
			B_DIFF:  b_op = {{8{diff[24]}}, diff};
			default: b_op = '0;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
		if (wr) begin
			case (ctl.word.acc_op)
				ACC_LOAD_LO: acc_q <= {27'b0, prod_q[60:30]};
				ACC_ADD_HI:  acc_q <= acc_q + prod_q[57:0];
				default:     acc_q <= acc_q;
			endcase
			case (ctl.word.wb)
				WB_D: begin
					x_q <= level_in;
					d_q <= sat56(lp_ext - hp_ext);
				end
				WB_E_DMAG: begin
					e_q    <= sat56(x_ext - lp_ext);
					dneg_q <= d_q[55];
					dmag_q <= d_q[55] ? 56'(-d_q) : d_q;
				end
				WB_EMAG: begin
					eneg_q <= e_q[55];
					emag_q <= e_q[55] ? 56'(-e_q) : e_q;
				end
				WB_GAIN: s_q <= gain_val;
				default: ;
			endcase
		end
	end

	// filter and resampler state, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q        <= '0;
			hp_q        <= '0;
			phase_q     <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr) begin
				case (ctl.word.wb)
					WB_HP: hp_q <= sat56(hp_sum);
					WB_LP: lp_q <= sat56(lp_sum);
					WB_OUT: begin
						out_valid_q <= 1'b1;
						phase_q     <= phase_q + {5'b0, cfg.step};
					end
					WB_END: begin
						phase_q <= phase_q - ONE_TICK;
						prev_q  <= s_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr && ctl.word.wb == WB_OUT) begin
			sample_q <= sat24(interp);
		end
	end

	assign status.emit     = $signed(phase_q) < $signed(ONE_TICK);
	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign sample_out      = sample_q;

endmodule

`default_nettype wire
